FILE: rtl/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// No dependencies; used by rgb_to_hsl_convert_top.sv and both testbench files.
package rgbhsl_pkg;

  // Output field widths.
  localparam int HUE_W = 15;
  localparam int SAT_W = 17;
  localparam int LIT_W = 9;

  // Quotient bits of both dividers; the saturation ratio reaches 2^16.
  localparam int QUO_W = 17;
  localparam int SAT_FRAC = 16;

  // Hue scale: 60 degrees in 1/64 degree units, and the full circle.
  localparam logic [15:0] HUE_SECTOR = 16'd3840;
  localparam logic [15:0] HUE_FULL   = 16'd23040;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  // Per-pixel data that rides alongside the dividers.
  typedef struct packed {
    logic [15:0]      hue_base;
    logic             diff_neg;
    logic             gray;
    logic [LIT_W-1:0] lightness;
  } side_t;

endpackage

FILE: rtl/rgb_to_hsl_convert_top.sv
// RGB to HSL converter, top level: channel compare, numerator setup, dividers.
// Depends on rgbhsl_pkg.sv and rgbhsl_div.sv.
//
// Usage: drive red, green and blue and raise start; a request is taken at
// every rising edge where start is high and busy is low. Busy never rises,
// so a new pixel may be issued in every clock cycle.
// Results leave on hue, saturation, lightness_twice and is_gray, held for
// exactly one cycle and marked by strobe. The receiver has no way to stall
// the block, so results must be taken when strobe is high.
// A result passes four setup stages (input capture, max/min select, span and
// denominator, numerators), 17 divider stages that each settle one
// quotient bit, and one output stage that wraps the hue.
// Throughput is one pixel per clock; the two pipelined dividers set the
// depth, not the rate.
// Synchronous reset clears every valid bit, so nothing is reported until a
// new request has passed all stages; data in flight at reset is dropped.
module rgb_to_hsl_convert_top #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [CHANNEL_BITS-1:0]             red,
  input  logic [CHANNEL_BITS-1:0]             green,
  input  logic [CHANNEL_BITS-1:0]             blue,
  output logic                                strobe,
  output logic [rgbhsl_pkg::HUE_W-1:0]        hue,
  output logic [rgbhsl_pkg::SAT_W-1:0]        saturation,
  output logic [rgbhsl_pkg::LIT_W-1:0]        lightness_twice,
  output logic                                is_gray
);

  localparam int C      = CHANNEL_BITS;
  localparam int QW     = rgbhsl_pkg::QUO_W;
  localparam int HNUM_W = C + 12;
  localparam int SNUM_W = C + rgbhsl_pkg::SAT_FRAC;
  localparam int LAT    = 4 + QW + 1;

  localparam logic [C-1:0] FULL = {C{1'b1}};

  // The pipeline never stalls, so a request can always be taken.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: capture the pixel.
  logic         v1;
  logic [C-1:0] r1, g1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    r1 <= red;
    g1 <= green;
    b1 <= blue;
  end

  // Stage 2: pick the maximum channel. Red wins ties over green and blue,
  // and green wins ties over blue. The two other channels give the hue
  // difference in the order that the sector calls for.
  logic                v2;
  logic [C-1:0]        mx2, mn2, pos2, neg2;
  rgbhsl_pkg::sector_t sec2;
  logic [C-1:0]        mx_c, mn_c, pos_c, neg_c;
  rgbhsl_pkg::sector_t sec_c;

  always_comb begin
    if (r1 >= g1 && r1 >= b1) begin
      mx_c  = r1;
      mn_c  = (g1 >= b1) ? b1 : g1;
      pos_c = g1;
      neg_c = b1;
      sec_c = rgbhsl_pkg::SECTOR_RED;
    end else if (g1 >= b1) begin
      mx_c  = g1;
      mn_c  = (r1 >= b1) ? b1 : r1;
      pos_c = b1;
      neg_c = r1;
      sec_c = rgbhsl_pkg::SECTOR_GREEN;
    end else begin
      mx_c  = b1;
      mn_c  = (r1 >= g1) ? g1 : r1;
      pos_c = r1;
      neg_c = g1;
      sec_c = rgbhsl_pkg::SECTOR_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mx2  <= mx_c;
    mn2  <= mn_c;
    pos2 <= pos_c;
    neg2 <= neg_c;
    sec2 <= sec_c;
  end

  // Stage 3: span, sum, saturation denominator and the signed hue difference.
  // The denominator never exceeds full scale, so it fits a channel width.
  // At lightness exactly one half the second formula applies.
  logic             v3;
  logic [C-1:0]     span3, den3, adiff3;
  rgbhsl_pkg::side_t side3;
  logic [C:0]       sum_c, dsub_c;
  logic [15:0]      base_c;

  assign sum_c  = {1'b0, mx2} + {1'b0, mn2};
  assign dsub_c = {FULL, 1'b0} - sum_c;

  always_comb begin
    case (sec2)
      rgbhsl_pkg::SECTOR_RED:   base_c = 16'd0;
      rgbhsl_pkg::SECTOR_GREEN: base_c = rgbhsl_pkg::HUE_SECTOR << 1;
      rgbhsl_pkg::SECTOR_BLUE:  base_c = rgbhsl_pkg::HUE_SECTOR << 2;
      default:                  base_c = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    span3           <= mx2 - mn2;
    den3            <= (sum_c < {1'b0, FULL}) ? sum_c[C-1:0] : dsub_c[C-1:0];
    adiff3          <= (pos2 >= neg2) ? (pos2 - neg2) : (neg2 - pos2);
    side3.hue_base  <= base_c;
    side3.diff_neg  <= (pos2 < neg2);
    side3.gray      <= (mx2 == mn2);
    side3.lightness <= rgbhsl_pkg::LIT_W'(sum_c);
  end

  // Stage 4: numerators. 3840 * diff is formed as diff * 4096 - diff * 256.
  logic              v4;
  logic [HNUM_W-1:0] hnum4;
  logic [SNUM_W-1:0] snum4;
  logic [C-1:0]      den4, span4;
  rgbhsl_pkg::side_t side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    hnum4 <= (HNUM_W'(adiff3) << 12) - (HNUM_W'(adiff3) << 8);
    snum4 <= SNUM_W'(span3) << rgbhsl_pkg::SAT_FRAC;
    den4  <= den3;
    span4 <= span3;
    side4 <= side3;
  end

  // Divider stages. A gray pixel divides by zero here; its quotients are
  // discarded at the output stage. Both quotients stay below 2^17 because
  // the hue difference never exceeds the span and the saturation
  // denominator is never below the span.
  logic [QW-1:0] hue_quo, sat_quo;

  rgbhsl_div #(
    .NUM_W (HNUM_W),
    .DEN_W (C),
    .QUO_W (QW)
  ) u_hue_div (
    .clk (clk),
    .num (hnum4),
    .den (span4),
    .quo (hue_quo)
  );

  rgbhsl_div #(
    .NUM_W (SNUM_W),
    .DEN_W (C),
    .QUO_W (QW)
  ) u_sat_div (
    .clk (clk),
    .num (snum4),
    .den (den4),
    .quo (sat_quo)
  );

  // Side data and valid bits travel in step with the divider stages.
  logic              dv    [QW];
  rgbhsl_pkg::side_t dside [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        dv[i] <= 1'b0;
      end
    end else begin
      dv[0] <= v4;
      for (int i = 1; i < QW; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dside[0] <= side4;
    for (int i = 1; i < QW; i++) begin
      dside[i] <= dside[i-1];
    end
  end

  // Output stage: add the sector base to the signed quotient, which was
  // truncated toward zero, and wrap a negative or overflowing hue into the
  // circle.
  rgbhsl_pkg::side_t sd;
  logic [15:0]       hq, hue_sum, hue_wrap;

  assign sd = dside[QW-1];
  assign hq = 16'(hue_quo);

  always_comb begin
    if (!sd.diff_neg) begin
      hue_sum = sd.hue_base + hq;
    end else if (hq > sd.hue_base) begin
      hue_sum = rgbhsl_pkg::HUE_FULL - (hq - sd.hue_base);
    end else begin
      hue_sum = sd.hue_base - hq;
    end
    hue_wrap = (hue_sum >= rgbhsl_pkg::HUE_FULL) ? (hue_sum - rgbhsl_pkg::HUE_FULL)
                                                  : hue_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dv[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    hue             <= sd.gray ? '0 : rgbhsl_pkg::HUE_W'(hue_wrap);
    saturation      <= sd.gray ? '0 : rgbhsl_pkg::SAT_W'(sat_quo);
    lightness_twice <= sd.lightness;
    is_gray         <= sd.gray;
  end

  // Every result traces back to a request that the block took.
  a_strobe_from_request: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

  // A gray pixel reports zero hue and zero saturation.
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_gray) |-> (hue == '0 && saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");

  // Hue stays inside one circle and saturation never exceeds one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (hue < rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_FULL) &&
                saturation <= rgbhsl_pkg::SAT_W'(1 << rgbhsl_pkg::SAT_FRAC)))
    else $error("hue or saturation out of range");

endmodule

FILE: rtl/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; instantiated twice by rgb_to_hsl_convert_top.sv.
module rgbhsl_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 8,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // Wide enough for the remainder and for the divisor at its largest shift.
  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [CMP_W-1:0] rem   [QUO_W];
  logic [DEN_W-1:0] dsr   [QUO_W];
  logic [QUO_W-1:0] quo_s [QUO_W];

  assign rem[0]   = CMP_W'(num);
  assign dsr[0]   = den;
  assign quo_s[0] = '0;

  // The caller guarantees the quotient fits in QUO_W bits.
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [CMP_W-1:0] trial;
    logic             take;
    logic [QUO_W-1:0] quo_new;

    assign trial   = CMP_W'(dsr[k]) << SH;
    assign take    = (rem[k] >= trial);
    assign quo_new = {quo_s[k][QUO_W-2:0], take};

    if (k < QUO_W - 1) begin : g_mid
      always_ff @(posedge clk) begin
        rem[k+1]   <= take ? (rem[k] - trial) : rem[k];
        dsr[k+1]   <= dsr[k];
        quo_s[k+1] <= quo_new;
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        quo <= quo_new;
      end
    end
  end

endmodule

FILE: tb/rgb_to_hsl_convert_checker.sv
// Scoreboard for the RGB to HSL converter: predicts each pixel's result and compares.
// Depends on rgbhsl_pkg.sv; instantiated beside the block by rgb_to_hsl_convert_top_test.sv.
`timescale 1ns / 1ps

module rgb_to_hsl_convert_checker
  import rgbhsl_pkg::*;
#(
  parameter int CH_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  input  logic              strobe,
  input  logic [HUE_W-1:0]  hue,
  input  logic [SAT_W-1:0]  saturation,
  input  logic [LIT_W-1:0]  lightness_twice,
  input  logic              is_gray,
  output int                fail_count,
  output int                outstanding
);

  localparam longint unsigned FULL_SCALE = (64'd1 << CH_W) - 1;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [LIT_W-1:0] lit;
    logic             gray;
  } hsl_result_t;

  hsl_result_t expected_hsl[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Hue is the sector base plus the channel difference scaled by 60 degrees over the
  // span, with the quotient truncated toward zero and negatives wrapped into the circle.
  function automatic hsl_result_t predict_hsl(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                              logic [CH_W-1:0] b);
    hsl_result_t    res;
    sector_t        sec;
    longint unsigned mx, mn, pos, neg, span, sum, base, quo, hue_v, den, sat_v;
    if (r >= g && r >= b) begin
      sec = SECTOR_RED;
      mx  = r;
      mn  = (g >= b) ? b : g;
      pos = g;
      neg = b;
    end else if (g >= r && g >= b) begin
      sec = SECTOR_GREEN;
      mx  = g;
      mn  = (r >= b) ? b : r;
      pos = b;
      neg = r;
    end else begin
      sec = SECTOR_BLUE;
      mx  = b;
      mn  = (r >= g) ? g : r;
      pos = r;
      neg = g;
    end
    span  = mx - mn;
    sum   = mx + mn;
    hue_v = 0;
    sat_v = 0;
    if (span != 0) begin
      case (sec)
        SECTOR_RED:   base = 0;
        SECTOR_GREEN: base = 2 * HUE_SECTOR;
        default:      base = 4 * HUE_SECTOR;
      endcase
      if (pos >= neg) begin
        hue_v = base + (HUE_SECTOR * (pos - neg)) / span;
      end else begin
        quo = (HUE_SECTOR * (neg - pos)) / span;
        hue_v = (quo > base) ? HUE_FULL - (quo - base) : base - quo;
      end
      if (hue_v >= HUE_FULL) hue_v -= HUE_FULL;
      // Lightness at exactly one half takes the second formula.
      den = (sum < FULL_SCALE) ? sum : 2 * FULL_SCALE - sum;
      if (den != 0) sat_v = (span << SAT_FRAC) / den;
    end
    res.hue  = hue_v[HUE_W-1:0];
    res.sat  = sat_v[SAT_W-1:0];
    res.lit  = sum[LIT_W-1:0];
    res.gray = (span == 0);
    return res;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    if (fail_count < PRINT_CAP)
      $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hsl_result_t want;
    if (!rst) begin
      if (start && !busy) expected_hsl.push_back(predict_hsl(red, green, blue));
      if (strobe) begin
        if (expected_hsl.size() == 0) begin
          report_mismatch("unexpected result, hue", hue, 0);
        end else begin
          want = expected_hsl.pop_front();
          if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
          if (saturation !== want.sat) report_mismatch("saturation", saturation, want.sat);
          if (lightness_twice !== want.lit)
            report_mismatch("lightness_twice", lightness_twice, want.lit);
          if (is_gray !== want.gray) report_mismatch("is_gray", is_gray, want.gray);
        end
      end
      outstanding <= expected_hsl.size();
    end
  end

endmodule

FILE: tb/rgb_to_hsl_convert_top_test.sv
// Testbench top for the RGB to HSL converter: clock, reset, pixel stimulus and verdict.
// Depends on rgbhsl_pkg.sv, rgb_to_hsl_convert_top.sv and rgb_to_hsl_convert_checker.sv.
`timescale 1ns / 1ps

module rgb_to_hsl_convert_top_test;
  import rgbhsl_pkg::*;

  localparam int CH_W = 8;
  localparam int CH_MAX = (1 << CH_W) - 1;
  // The drain wait and the watchdog are sized well above the block's latency plus
  // the longest sender gap that is at all likely.
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 288;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             strobe;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [LIT_W-1:0] lightness_twice;
  logic             is_gray;

  int fail_count;
  int outstanding;
  int idle_pct;
  int quiet_cycles;

  rgb_to_hsl_convert_top #(.CHANNEL_BITS(CH_W)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue),
    .strobe(strobe), .hue(hue), .saturation(saturation),
    .lightness_twice(lightness_twice), .is_gray(is_gray)
  );

  // The checker sees the same pins as the block and keeps its own list of
  // expected pixels; the top only drives requests and reads the failure and outstanding counts.
  rgb_to_hsl_convert_checker #(.CH_W(CH_W)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue),
    .strobe(strobe), .hue(hue), .saturation(saturation),
    .lightness_twice(lightness_twice), .is_gray(is_gray),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: any cycle in which neither a request nor a result is taken counts
  // toward the limit. A healthy run never gets close, even with long sender gaps.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb_to_hsl_convert_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issues one pixel request. Before it, the sender may sit idle for a random
  // number of cycles, each one idle with probability idle_pct. Start is only
  // lowered when an idle cycle really follows, so back-to-back requests keep it
  // high without a drop in between. The task returns at the edge that takes the
  // request; start is left high for the caller to reuse or drop.
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    do @(posedge clk); while (busy);
  endtask

  // Random pixels are biased toward the corners of the conversion: gray pixels,
  // ties for the maximum, channels at the extremes, and pixels whose lightness
  // sits at or next to one half, where the saturation formula switches.
  task automatic send_random_pixel();
    int unsigned shape, hi, lo, mid, tweak;
    logic [CH_W-1:0] ch [3];
    int unsigned extremes [6];
    extremes = '{0, 1, CH_MAX / 2, CH_MAX / 2 + 1, CH_MAX - 1, CH_MAX};
    shape = $urandom_range(9);
    case (shape)
      6: begin
        hi = $urandom_range(CH_MAX);
        ch = '{CH_W'(hi), CH_W'(hi), CH_W'(hi)};
      end
      7: begin
        // Two channels share the maximum, the third is at or below it.
        hi = $urandom_range(CH_MAX);
        lo = $urandom_range(hi);
        case ($urandom_range(2))
          0: ch = '{CH_W'(hi), CH_W'(hi), CH_W'(lo)};
          1: ch = '{CH_W'(hi), CH_W'(lo), CH_W'(hi)};
          default: ch = '{CH_W'(lo), CH_W'(hi), CH_W'(hi)};
        endcase
      end
      8: begin
        ch[0] = CH_W'(extremes[$urandom_range(5)]);
        ch[1] = CH_W'(extremes[$urandom_range(5)]);
        ch[2] = CH_W'(extremes[$urandom_range(5)]);
      end
      9: begin
        // max + min lands on full scale or one step either side of it.
        hi = $urandom_range(CH_MAX, (CH_MAX + 1) / 2);
        tweak = $urandom_range(2);
        lo = CH_MAX - hi;
        if (tweak == 1 && lo > 0) lo = lo - 1;
        if (tweak == 2 && lo < hi) lo = lo + 1;
        mid = $urandom_range(hi, lo);
        case ($urandom_range(5))
          0: ch = '{CH_W'(hi), CH_W'(mid), CH_W'(lo)};
          1: ch = '{CH_W'(hi), CH_W'(lo), CH_W'(mid)};
          2: ch = '{CH_W'(mid), CH_W'(hi), CH_W'(lo)};
          3: ch = '{CH_W'(lo), CH_W'(hi), CH_W'(mid)};
          4: ch = '{CH_W'(mid), CH_W'(lo), CH_W'(hi)};
          default: ch = '{CH_W'(lo), CH_W'(mid), CH_W'(hi)};
        endcase
      end
      default: begin
        ch[0] = CH_W'($urandom_range(CH_MAX));
        ch[1] = CH_W'($urandom_range(CH_MAX));
        ch[2] = CH_W'($urandom_range(CH_MAX));
      end
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  initial begin
    int phase_idle [4];
    rst      = 1'b1;
    start    = 1'b0;
    red      = '0;
    green    = '0;
    blue     = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    // The sender is idle in none of the cycles, then 63 of a hundred, none again,
    // then 33 of a hundred. The receiver cannot stall, so it has no phases.
    phase_idle = '{0, 63, 0, 33};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: black, white, the primaries and secondaries, every tie
    // for the maximum, gray, lightness exactly at one half and just below it,
    // a red maximum with a negative hue that must wrap, the smallest spans,
    // and full saturation at a lightness just under one half.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd200, 8'd55,  8'd100);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd254);
    send_pixel(8'd254, 8'd0,   8'd0);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd85,  8'd170, 8'd255);
    send_pixel(8'd10,  8'd20,  8'd30);
    send_pixel(8'd30,  8'd20,  8'd10);
    send_pixel(8'd255, 8'd254, 8'd255);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_pixel();
    end
    start <= 1'b0;

    // Wait until every expected pixel has come back, then a little longer so a
    // stray strobe after the last result is still caught.
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rgb_to_hsl_convert_top: match");
    end else begin
      $display("rgb_to_hsl_convert_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_div.sv
rtl/rgb_to_hsl_convert_top.sv
tb/rgb_to_hsl_convert_checker.sv
tb/rgb_to_hsl_convert_top_test.sv
